### hdl/pvpd_pkg.sv
package pvpd_pkg;

    // Field widths
    localparam int VOLT_W  = 16;
    localparam int ANG_W   = 16;
    localparam int CFG_W   = 16;
    localparam int OUT_W   = 8;

    // Angle resolution and duty scale
    localparam int ANGLE_BITS = 16;
    localparam int DUTY_FULL  = 255;
    localparam int DUTY_BITS  = $clog2(DUTY_FULL + 1);

    // Register reset values
    localparam logic [CFG_W-1:0] CAP_RESET    = 16'd2816;
    localparam logic [CFG_W-1:0] SUPPLY_RESET = 16'd3226;

    // Sine/cosine polynomial, Q16
    localparam int X_W      = 17;
    localparam int SIN_W    = 18;
    localparam int SIN_ONE  = 65536;
    localparam int POLY_TOP = 11;
    localparam int POLY_C [4] = '{307, 5223, 42334, 102944};

    // Park and Clarke arithmetic
    localparam int PROD_W    = 34;
    localparam int AB_W      = 35;
    localparam int SPLIT     = 17;
    localparam int SQRT3_Q16 = 113512;
    localparam int PH_W      = 56;

    // Duty division
    localparam int D_W   = 32;
    localparam int V24_W = 32;
    localparam int NUM_W = V24_W + DUTY_BITS;
    localparam int REM_W = D_W + 1;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [0:0] {
        CFG_VOLTAGE_CAP    = 1'b0,
        CFG_SUPPLY_VOLTAGE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] voltage_cap;
        logic [CFG_W-1:0] supply_voltage;
    } t_cfg;

    typedef struct packed {
        logic signed [AB_W-1:0] alpha;
        logic signed [AB_W-1:0] beta;
    } t_park;

endpackage

### hdl/pvpd_cmd_if.sv
interface pvpd_cmd_if import pvpd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [VOLT_W-1:0] volt_q;
    logic signed [VOLT_W-1:0] volt_d;
    logic [ANG_W-1:0]         elec_angle;

    modport source (output valid, output volt_q, output volt_d, output elec_angle,
                    input ready);
    modport sink   (input valid, input volt_q, input volt_d, input elec_angle,
                    output ready);
endinterface

### hdl/pvpd_duty_if.sv
interface pvpd_duty_if import pvpd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] duty_a;
    logic [OUT_W-1:0] duty_b;
    logic [OUT_W-1:0] duty_c;

    modport source (output valid, output duty_a, output duty_b, output duty_c,
                    input ready);
    modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                    output ready);
endinterface

### hdl/pvpd_front.sv
module pvpd_front import pvpd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pvpd_cmd_if.sink  i_cmd,
    output logic      o_park_valid,
    input  logic      i_park_ready,
    output t_park     o_park
);

    localparam int NSTG = 9;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic                     en;
    logic [NSTG-1:0]          r_vld;

    logic [ANGLE_BITS-1:0]    ang    [2];
    logic [1:0]               quad   [2];
    logic [ANGLE_BITS+15:0]   frac_w [2];
    logic [X_W-1:0]           n_x    [2];
    logic [2*X_W-1:0]         m_sq   [2];
    logic [2*X_W-1:0]         m_poly [2:5][2];
    logic [X_W-1:0]           n_t    [2:5][2];
    logic [2*X_W-1:0]         m_s    [2];
    logic [X_W:0]             s_mag  [2];
    logic signed [SIN_W-1:0]  n_s    [2];

    logic [X_W-1:0]           r_x    [0:5][2];
    logic                     r_neg  [0:5][2];
    logic [X_W-1:0]           r_x2   [1:4][2];
    logic [X_W-1:0]           r_t    [2:5][2];
    logic signed [SIN_W-1:0]  r_s    [2];
    logic signed [VOLT_W-1:0] r_vq   [0:6];
    logic signed [VOLT_W-1:0] r_vd   [0:6];
    logic signed [PROD_W-1:0] r_pdc, r_pqs, r_pds, r_pqc;
    logic signed [AB_W-1:0]   r_alpha, r_beta;

    // whole pipeline moves whenever the last word can leave
    assign en          = !r_vld[NSTG-1] || i_park_ready;
    assign i_cmd.ready = en;

    // quadrant fold of the angle for sine (lane 0) and cosine (lane 1)
    always_comb begin
        ang[0] = ANGLE_BITS'(i_cmd.elec_angle);
        ang[1] = ang[0] + QUARTER;
        for (int k = 0; k < 2; k++) begin
            quad[k]   = ang[k][ANGLE_BITS-1 -: 2];
            frac_w[k] = {ang[k][ANGLE_BITS-3:0], 18'b0} >> ANGLE_BITS;
            n_x[k]    = quad[k][0] ? (X_W'(SIN_ONE) - X_W'(frac_w[k])) : X_W'(frac_w[k]);
        end
    end

    // one multiply per stage of the Horner chain
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            m_sq[k]      = r_x[0][k] * r_x[0][k];
            m_poly[2][k] = r_x2[1][k] * X_W'(POLY_TOP);
            for (int j = 3; j <= 5; j++) begin
                m_poly[j][k] = r_x2[j-1][k] * r_t[j-1][k];
            end
            for (int j = 2; j <= 5; j++) begin
                n_t[j][k] = X_W'(POLY_C[j-2]) - X_W'(m_poly[j][k] >> 16);
            end
            m_s[k]   = r_x[5][k] * r_t[5][k];
            s_mag[k] = ((m_s[k] >> 16) > (2*X_W)'(SIN_ONE)) ? (X_W+1)'(SIN_ONE)
                                                             : (X_W+1)'(m_s[k] >> 16);
            n_s[k]   = r_neg[5][k] ? -$signed(s_mag[k]) : $signed(s_mag[k]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_cmd.valid};
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                r_x[0][k]   <= n_x[k];
                r_neg[0][k] <= quad[k][1];
                for (int j = 1; j <= 5; j++) begin
                    r_x[j][k]   <= r_x[j-1][k];
                    r_neg[j][k] <= r_neg[j-1][k];
                end
                r_x2[1][k] <= X_W'(m_sq[k] >> 16);
                for (int j = 2; j <= 4; j++) begin
                    r_x2[j][k] <= r_x2[j-1][k];
                end
                for (int j = 2; j <= 5; j++) begin
                    r_t[j][k] <= n_t[j][k];
                end
                r_s[k] <= n_s[k];
            end
            r_vq[0] <= i_cmd.volt_q;
            r_vd[0] <= i_cmd.volt_d;
            for (int j = 1; j <= 6; j++) begin
                r_vq[j] <= r_vq[j-1];
                r_vd[j] <= r_vd[j-1];
            end
            // inverse Park: lane 0 is sine, lane 1 cosine
            r_pdc   <= r_vd[6] * r_s[1];
            r_pqs   <= r_vq[6] * r_s[0];
            r_pds   <= r_vd[6] * r_s[0];
            r_pqc   <= r_vq[6] * r_s[1];
            r_alpha <= AB_W'(r_pdc) - AB_W'(r_pqs);
            r_beta  <= AB_W'(r_pds) + AB_W'(r_pqc);
        end
    end

    assign o_park_valid = r_vld[NSTG-1];
    assign o_park.alpha = r_alpha;
    assign o_park.beta  = r_beta;

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> (r_s[0] <= SIN_W'(SIN_ONE)) && (r_s[0] >= -SIN_W'(SIN_ONE)) &&
                     (r_s[1] <= SIN_W'(SIN_ONE)) && (r_s[1] >= -SIN_W'(SIN_ONE)))
        else $error("sine or cosine out of unit range");

endmodule

### hdl/pvpd_queue.sv
module pvpd_queue import pvpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_park i_push_data,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_park o_pop_data
);

    t_park           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_AW:0]   r_count;
    logic            push, pop;

    assign o_push_ready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + 1'b1;
            if (pop)  r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= i_push_data;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue fill count overflow");

    a_count_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count not reduced on pop");

endmodule

### hdl/pvpd_back.sv
module pvpd_back import pvpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_park_valid,
    output logic        o_park_ready,
    input  t_park       i_park,
    pvpd_duty_if.source o_duty
);

    localparam int QB = DUTY_BITS;
    localparam int NB = QB + 5;
    localparam logic [SIN_W-1:0] SQRT3_S = SIN_W'(SQRT3_Q16);

    logic                     en;
    logic [NB-1:0]            r_vld;
    logic [D_W-1:0]           dvs;
    logic signed [PH_W-1:0]   capw, offs, a16;
    logic [SPLIT-1:0]         b_lo;
    logic signed [AB_W-SPLIT-1:0] b_hi;
    logic signed [PH_W-1:0]   n_ph  [3];
    logic signed [PH_W-1:0]   clamp [3];
    logic [V24_W-1:0]         v24   [3];
    logic [REM_W-1:0]         rin   [1:QB][3];

    logic signed [AB_W-1:0]   r_alpha0, r_alpha1;
    logic [2*SPLIT-1:0]       r_pp_lo;
    logic signed [AB_W-SPLIT+SIN_W-1:0] r_pp_hi;
    logic signed [PH_W-1:0]   r_bs;
    logic signed [PH_W-1:0]   r_ph  [3];
    logic [REM_W-1:0]         r_rem [0:QB][3];
    logic [QB-1:0]            r_low [0:QB-1][3];
    logic [QB-1:0]            r_quo [0:QB][3];
    logic                     r_sat [0:QB][3];
    logic                     r_nz  [0:QB][3];
    logic [OUT_W-1:0]         r_duty [3];

    assign en           = !r_vld[NB-1] || o_duty.ready;
    assign o_park_ready = en;

    assign dvs  = {i_cfg.supply_voltage, 16'b0};
    assign capw = PH_W'({i_cfg.voltage_cap, 33'b0});
    assign offs = PH_W'({i_cfg.supply_voltage, 32'b0});
    assign b_lo = i_park.beta[SPLIT-1:0];
    assign b_hi = i_park.beta[AB_W-1:SPLIT];
    assign a16  = PH_W'(r_alpha1) <<< 16;

    // Clarke phases, clamp and division steps
    always_comb begin
        n_ph[0] = (PH_W'(r_alpha1) <<< 17) + offs;
        n_ph[1] = r_bs - a16 + offs;
        n_ph[2] = -r_bs - a16 + offs;
        for (int p = 0; p < 3; p++) begin
            if (r_ph[p] < 0) begin
                clamp[p] = '0;
            end else if (r_ph[p] > capw) begin
                clamp[p] = capw;
            end else begin
                clamp[p] = r_ph[p];
            end
            v24[p] = V24_W'(clamp[p] >>> 17);
            for (int k = 1; k <= QB; k++) begin
                rin[k][p] = {r_rem[k-1][p][REM_W-2:0], r_low[k-1][p][QB-k]};
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NB-2:0], i_park_valid};
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            // beta times sqrt3 in two partial products
            r_alpha0 <= i_park.alpha;
            r_pp_lo  <= b_lo * SPLIT'(SQRT3_Q16);
            r_pp_hi  <= b_hi * $signed(SQRT3_S);
            r_alpha1 <= r_alpha0;
            r_bs     <= (PH_W'(r_pp_hi) <<< SPLIT) + PH_W'(r_pp_lo);
            for (int p = 0; p < 3; p++) begin
                r_ph[p] <= n_ph[p];
                // division set-up
                r_sat[0][p] <= (v24[p] >= dvs);
                r_nz[0][p]  <= (v24[p] != '0);
                r_rem[0][p] <= REM_W'((NUM_W'(v24[p]) * NUM_W'(DUTY_FULL)) >> QB);
                r_low[0][p] <= QB'(NUM_W'(v24[p]) * NUM_W'(DUTY_FULL));
                r_quo[0][p] <= '0;
                // one quotient bit per stage
                for (int k = 1; k <= QB; k++) begin
                    if (rin[k][p] >= {1'b0, dvs}) begin
                        r_rem[k][p] <= rin[k][p] - {1'b0, dvs};
                        r_quo[k][p] <= {r_quo[k-1][p][QB-2:0], 1'b1};
                    end else begin
                        r_rem[k][p] <= rin[k][p];
                        r_quo[k][p] <= {r_quo[k-1][p][QB-2:0], 1'b0};
                    end
                    r_sat[k][p] <= r_sat[k-1][p];
                    r_nz[k][p]  <= r_nz[k-1][p];
                end
                // low numerator bits still to be brought down
                for (int k = 1; k < QB; k++) begin
                    r_low[k][p] <= r_low[k-1][p];
                end
                // output word
                if (r_sat[QB][p]) begin
                    r_duty[p] <= r_nz[QB][p] ? OUT_W'(DUTY_FULL) : '0;
                end else begin
                    r_duty[p] <= OUT_W'(r_quo[QB][p]);
                end
            end
        end
    end

    assign o_duty.valid  = r_vld[NB-1];
    assign o_duty.duty_a = r_duty[0];
    assign o_duty.duty_b = r_duty[1];
    assign o_duty.duty_c = r_duty[2];

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[QB+3] && !r_sat[QB][0]) |-> (r_rem[QB][0] < {1'b0, dvs}))
        else $error("division remainder not below divisor");

endmodule

### hdl/phase_voltage_pwm_duty.sv
// Inverse Park / inverse Clarke sinusoidal PWM duty, fully pipelined.
// A word accepted at one clock edge passes 9 sine/Park stages, the first loaded at
// the accepting edge, 1 queue stage and 13 Clarke/divide stages including the output
// register. The duty divider resolves one quotient bit per stage.
// Throughput: one word per cycle while the output is not stalled.
// Reset (synchronous, active low) empties all stages and the queue and loads the
// voltage cap and supply registers with their default values.
module phase_voltage_pwm_duty import pvpd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    pvpd_cmd_if.sink         i_cmd,
    pvpd_duty_if.source      o_duty
);

    t_cfg  r_cfg;
    logic  fr_valid, fr_ready, bk_valid, bk_ready;
    t_park fr_data, bk_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.voltage_cap    <= CAP_RESET;
            r_cfg.supply_voltage <= SUPPLY_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_VOLTAGE_CAP:    r_cfg.voltage_cap    <= i_cfg_wdata;
                CFG_SUPPLY_VOLTAGE: r_cfg.supply_voltage <= i_cfg_wdata;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    pvpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_park_valid (fr_valid),
        .i_park_ready (fr_ready),
        .o_park       (fr_data)
    );

    pvpd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_data  (fr_data),
        .o_pop_valid  (bk_valid),
        .i_pop_ready  (bk_ready),
        .o_pop_data   (bk_data)
    );

    pvpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_park_valid (bk_valid),
        .o_park_ready (bk_ready),
        .i_park       (bk_data),
        .o_duty       (o_duty)
    );

endmodule
